>>> sv/sha1r_pkg.sv
`timescale 1ns / 1ps

package sha1r_pkg;

  localparam logic [6:0]  ROUNDS_MAX = 7'd80;
  localparam logic [0:0]  MODE_CHAIN = 1'b0;
  localparam logic [0:0]  MODE_MSG   = 1'b1;
  localparam logic [3:0]  MSG_LAST_INDEX   = 4'd15;
  localparam logic [3:0]  CHAIN_WORDS      = 4'd5;
  localparam logic [2:0]  DIGEST_LAST_INDEX = 3'd4;

  localparam logic [31:0] K0 = 32'h5a827999;
  localparam logic [31:0] K1 = 32'h6ed9eba1;
  localparam logic [31:0] K2 = 32'h8f1bbcdc;
  localparam logic [31:0] K3 = 32'hca62c1d6;

  typedef struct packed {
    logic [0:0]  mode;
    logic [3:0]  word_index;
    logic [31:0] word;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  out_index;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic       accept;
    logic       load;
    logic       round;
    logic       emit;
    logic [6:0] round_idx;
    logic [2:0] emit_idx;
  } ctl_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

endpackage

>>> sv/sha1r_datapath.sv
`timescale 1ns / 1ps

module sha1r_datapath (
  input  logic                  clk,
  input  logic                  rst_n,
  input  sha1r_pkg::ctl_cmd_t   cmd,
  output sha1r_pkg::dp_status_t status,
  input  sha1r_pkg::in_item_t   in_item,
  input  logic                  out_stall,
  output logic                  out_valid,
  output sha1r_pkg::out_item_t  out_item
);

  logic [31:0] msg_r  [16];
  logic [31:0] win_r  [16];
  logic [31:0] work_r [5];
  logic [31:0] chain_r [5];
  logic        out_valid_r;
  sha1r_pkg::out_item_t out_item_r;

  logic [31:0] a, b, c, d, e;
  logic [31:0] f, k, t, new_w, sum;

  assign a = work_r[0];
  assign b = work_r[1];
  assign c = work_r[2];
  assign d = work_r[3];
  assign e = work_r[4];

  always_comb begin
    if (cmd.round_idx inside {[7'd0:7'd19]}) begin
      f = (b & c) | (~b & d);
      k = sha1r_pkg::K0;
    end else if (cmd.round_idx inside {[7'd20:7'd39]}) begin
      f = b ^ c ^ d;
      k = sha1r_pkg::K1;
    end else if (cmd.round_idx inside {[7'd40:7'd59]}) begin
      f = (b & c) | (b & d) | (c & d);
      k = sha1r_pkg::K2;
    end else begin
      f = b ^ c ^ d;
      k = sha1r_pkg::K3;
    end
  end

  assign t = {a[26:0], a[31:27]} + f + e + k + win_r[0];

  logic [31:0] mix;
  assign mix   = win_r[13] ^ win_r[8] ^ win_r[2] ^ win_r[0];
  assign new_w = {mix[30:0], mix[31]};

  assign sum = chain_r[cmd.emit_idx] + work_r[cmd.emit_idx];

  always_ff @(posedge clk) begin
    if (cmd.accept && in_item.mode == sha1r_pkg::MODE_MSG) begin
      msg_r[in_item.word_index] <= in_item.word;
    end
  end

  // The window holds W[i] .. W[i+15] at round i, so the schedule advances by shifting.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int i = 0; i < 16; i++) begin
        win_r[i] <= msg_r[i];
      end
      for (int i = 0; i < 5; i++) begin
        work_r[i] <= chain_r[i];
      end
    end else if (cmd.round) begin
      for (int i = 0; i < 15; i++) begin
        win_r[i] <= win_r[i + 1];
      end
      win_r[15] <= new_w;
      work_r[0] <= t;
      work_r[1] <= a;
      work_r[2] <= {b[1:0], b[31:2]};
      work_r[3] <= c;
      work_r[4] <= d;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 5; i++) begin
        chain_r[i] <= 32'd0;
      end
    end else if (cmd.emit) begin
      chain_r[cmd.emit_idx] <= sum;
    end else if (cmd.accept && in_item.mode == sha1r_pkg::MODE_CHAIN &&
                 in_item.word_index < sha1r_pkg::CHAIN_WORDS) begin
      chain_r[in_item.word_index[2:0]] <= in_item.word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_item_r.digest_word <= sum;
      out_item_r.out_index   <= cmd.emit_idx;
      out_item_r.last        <= (cmd.emit_idx == sha1r_pkg::DIGEST_LAST_INDEX);
    end
  end

  assign status.out_free = !out_valid_r || !out_stall;
  assign out_valid       = out_valid_r;
  assign out_item        = out_item_r;

endmodule

>>> sv/sha1r_controller.sv
`timescale 1ns / 1ps

module sha1r_controller (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  sha1r_pkg::in_item_t   in_item,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [6:0]            cfg_data,
  input  sha1r_pkg::dp_status_t status,
  output sha1r_pkg::ctl_cmd_t   cmd
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_START = 2'd1;
  localparam logic [1:0] ST_ROUND = 2'd2;
  localparam logic [1:0] ST_OUT   = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic [6:0] round_idx_r, round_idx_nxt;
  logic [2:0] emit_idx_r, emit_idx_nxt;
  logic [6:0] round_count_r;

  always_comb begin
    state_nxt     = state_r;
    round_idx_nxt = round_idx_r;
    emit_idx_nxt  = emit_idx_r;
    cmd.accept    = 1'b0;
    cmd.load      = 1'b0;
    cmd.round     = 1'b0;
    cmd.emit      = 1'b0;
    cmd.round_idx = round_idx_r;
    cmd.emit_idx  = emit_idx_r;
    case (state_r)
      ST_IDLE: begin
        cmd.accept = in_valid;
        if (in_valid && in_item.mode == sha1r_pkg::MODE_MSG &&
            in_item.word_index == sha1r_pkg::MSG_LAST_INDEX) begin
          state_nxt = ST_START;
        end
      end
      ST_START: begin
        cmd.load      = 1'b1;
        round_idx_nxt = 7'd0;
        emit_idx_nxt  = 3'd0;
        state_nxt     = (round_count_r == 7'd0) ? ST_OUT : ST_ROUND;
      end
      ST_ROUND: begin
        cmd.round     = 1'b1;
        round_idx_nxt = round_idx_r + 7'd1;
        if (round_idx_r == round_count_r - 7'd1) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (status.out_free) begin
          cmd.emit     = 1'b1;
          emit_idx_nxt = emit_idx_r + 3'd1;
          if (emit_idx_r == sha1r_pkg::DIGEST_LAST_INDEX) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      round_idx_r <= 7'd0;
      emit_idx_r  <= 3'd0;
    end else begin
      state_r     <= state_nxt;
      round_idx_r <= round_idx_nxt;
      emit_idx_r  <= emit_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      round_count_r <= sha1r_pkg::ROUNDS_MAX;
    end else if (cfg_valid && cfg_ready) begin
      round_count_r <= (cfg_data > sha1r_pkg::ROUNDS_MAX) ? sha1r_pkg::ROUNDS_MAX : cfg_data;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;

endmodule

>>> sv/sha1_compression_reduced_rounds.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake           Carries
// in_       input      in_valid/in_stall   mode, word_index, word
// out_      output     out_valid/out_stall digest_word, out_index, last
// cfg_      input      cfg_valid/cfg_ready round_count (saturates at 80)
//
// Chaining words and message words 0 to 14 are taken unstalled while idle.
// Word 15 stalls the input through the load, R rounds (R = round_count) and
// the five digest emits; one round per cycle uses the single round adder.
// Each digest word waits in the output register; out_stall holds the emit step.
// Synchronous reset clears the chaining words and sets round_count to 80.

module sha1_compression_reduced_rounds (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  sha1r_pkg::in_item_t  in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output sha1r_pkg::out_item_t out_item,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [6:0]           cfg_data
);

  sha1r_pkg::ctl_cmd_t   cmd;
  sha1r_pkg::dp_status_t status;

  sha1r_controller u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .status    (status),
    .cmd       (cmd)
  );

  sha1r_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .in_item   (in_item),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !(out_valid && out_stall))
    else $error("digest word emitted over a waiting result");

  a_run_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_item.mode == sha1r_pkg::MODE_MSG &&
     in_item.word_index == sha1r_pkg::MSG_LAST_INDEX) |=> in_stall)
    else $error("input not stalled after the final message word");

  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.last) |-> out_item.out_index == sha1r_pkg::DIGEST_LAST_INDEX)
    else $error("last flag on a digest word other than the fifth");

  a_round_vs_emit: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.round && cmd.emit) && !(cmd.accept && (cmd.round || cmd.emit || cmd.load)))
    else $error("conflicting datapath commands");

endmodule
